>>> hdl/htw_pkg.sv
// Package with the shared types and constants of the timer wheel.
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_DEPTH = 8;
  localparam int ID_WIDTH = 16;
  localparam int N_ENTRIES = SLOT_COUNT * SLOT_DEPTH;
  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int DEPTH_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int ENTRY_W = $clog2(N_ENTRIES);
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_EXPIRED = 3'd0,
    KIND_ADD_OK = 3'd1,
    KIND_SLOT_FULL = 3'd2,
    KIND_REMOVED = 3'd3,
    KIND_NOT_FOUND = 3'd4
  } kind_t;

  // One classified command as it travels from the front end to the engine.
  typedef struct packed {
    action_t action;
    logic [ID_WIDTH-1:0] id;
    logic [15:0] delay;
  } cmd_t;
endpackage
`default_nettype wire

>>> hdl/htw_front.sv
// Front end: takes input beats, drops unused actions and queues commands.
`timescale 1ns / 1ps
`default_nettype none
module htw_front import htw_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] in_action,
  input wire logic [15:0] in_timer_id,
  input wire logic [15:0] in_delay_ticks,
  output logic cmd_valid,
  input wire logic cmd_take,
  output cmd_t cmd
);
  localparam int QW = $clog2(QUEUE_DEPTH);

  cmd_t q_r [QUEUE_DEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0] cnt_r;
  logic push, pop;

  // Unused action code is accepted and discarded.
  assign in_stall = (cnt_r == (QW+1)'(QUEUE_DEPTH));
  assign push = in_valid && !in_stall && (in_action != ACT_NONE);
  assign pop = cmd_take && cmd_valid;
  assign cmd_valid = (cnt_r != '0);
  assign cmd = q_r[rp_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{action: action_t'(in_action),
                     id: in_timer_id[ID_WIDTH-1:0], delay: in_delay_ticks};
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

>>> hdl/htw_engine.sv
// Back end: walks the entry memories to carry out tick, add and remove.
`timescale 1ns / 1ps
`default_nettype none
module htw_engine import htw_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic cmd_valid,
  output logic cmd_take,
  input wire cmd_t cmd,
  output logic out_valid,
  input wire logic out_stall,
  output logic [2:0] out_kind,
  output logic [15:0] out_result_id,
  output logic out_last
);
  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_READ = 7'b0000100,
    ST_TICK = 7'b0001000,
    ST_ADD = 7'b0010000,
    ST_REM = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [31:0] time_r;
  logic valid_mem [N_ENTRIES];
  logic [ID_WIDTH-1:0] owner_mem [N_ENTRIES];
  logic [31:0] expiry_mem [N_ENTRIES];
  logic valid_q_r;
  logic [ID_WIDTH-1:0] owner_q_r;
  logic [31:0] expiry_q_r;
  cmd_t cmd_r;
  logic [ENTRY_W:0] idx_r;
  logic found_r;
  logic pend_r;
  logic [ID_WIDTH-1:0] pend_id_r;
  logic [ENTRY_W-1:0] ent;
  logic [31:0] diff;
  logic due, is_end, hit;
  logic [31:0] sum;
  logic [ENTRY_W:0] idx_first;
  logic step;
  logic vwe, vdata;

  // Output register.
  logic ov_r;
  logic [2:0] ok_r;
  logic [15:0] oid_r;
  logic ol_r;
  logic emit;
  logic [2:0] ek;
  logic [15:0] eid;
  logic el;
  logic out_free;

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_result_id = oid_r;
  assign out_last = ol_r;
  assign out_free = !ov_r || !out_stall;

  assign ent = idx_r[ENTRY_W-1:0];
  assign diff = time_r - expiry_q_r;
  assign due = valid_q_r && !diff[31];
  assign hit = valid_q_r && (owner_q_r == cmd_r.id);
  assign sum = time_r + 32'(cmd.delay);
  assign cmd_take = (state_r == ST_IDLE) && cmd_valid;

  // Last entry of the current walk.
  always_comb begin
    if (cmd_r.action == ACT_REMOVE) begin
      is_end = (idx_r == (ENTRY_W+1)'(N_ENTRIES - 1));
    end else begin
      is_end = (idx_r[DEPTH_W-1:0] == DEPTH_W'(SLOT_DEPTH - 1)) || (SLOT_DEPTH == 1);
    end
  end

  // Start entry for a new command.
  always_comb begin
    idx_first = '0;
    unique case (cmd.action)
      ACT_TICK: idx_first = (ENTRY_W+1)'({time_r[SLOT_W-1:0], {DEPTH_W{1'b0}}});
      ACT_ADD: idx_first = (ENTRY_W+1)'({sum[SLOT_W-1:0], {DEPTH_W{1'b0}}});
      default: idx_first = '0;
    endcase
    if (SLOT_DEPTH == 1 && cmd.action != ACT_REMOVE)
      idx_first = (ENTRY_W+1)'(cmd.action == ACT_TICK ? time_r[SLOT_W-1:0] : sum[SLOT_W-1:0]);
  end

  // Result of the current step. A tick keeps its newest expiry in a pending
  // register so that the final one can be sent with last set when the walk ends.
  always_comb begin
    emit = 1'b0;
    ek = KIND_EXPIRED;
    eid = 16'(pend_id_r);
    el = 1'b0;
    unique case (state_r)
      ST_TICK: begin
        emit = due && pend_r;
      end
      ST_ADD: begin
        eid = 16'(cmd_r.id);
        if (!valid_q_r) begin
          emit = 1'b1;
          ek = KIND_ADD_OK;
          el = 1'b1;
        end else if (is_end) begin
          emit = 1'b1;
          ek = KIND_SLOT_FULL;
          el = 1'b1;
        end
      end
      ST_REM: begin
        eid = 16'(cmd_r.id);
        if (is_end) begin
          emit = 1'b1;
          ek = (found_r || hit) ? KIND_REMOVED : KIND_NOT_FOUND;
          el = 1'b1;
        end
      end
      ST_DONE: begin
        emit = pend_r;
        el = 1'b1;
      end
      default: ;
    endcase
  end

  // A working step advances unless its beat meets a full output register.
  assign step = ((state_r == ST_TICK) || (state_r == ST_ADD) || (state_r == ST_REM)
                 || (state_r == ST_DONE)) && !(emit && !out_free);

  // Valid store write for the current step or the clearing pass.
  always_comb begin
    vwe = 1'b0;
    vdata = 1'b0;
    unique case (state_r)
      ST_CLEAR: vwe = 1'b1;
      ST_TICK: vwe = step && due;
      ST_ADD: begin
        vwe = step && !valid_q_r;
        vdata = 1'b1;
      end
      ST_REM: vwe = step && hit;
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (idx_r == (ENTRY_W+1)'(N_ENTRIES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: if (cmd_valid) state_nxt = ST_READ;
      ST_READ: begin
        unique case (cmd_r.action)
          ACT_TICK: state_nxt = ST_TICK;
          ACT_ADD: state_nxt = ST_ADD;
          default: state_nxt = ST_REM;
        endcase
      end
      ST_TICK, ST_REM: if (step) state_nxt = is_end ? ST_DONE : ST_READ;
      ST_ADD: if (step) state_nxt = emit ? ST_DONE : ST_READ;
      ST_DONE: if (step) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory read, registered, and memory writes.
  always_ff @(posedge clk) begin
    valid_q_r <= valid_mem[ent];
    owner_q_r <= owner_mem[ent];
    expiry_q_r <= expiry_mem[ent];
    if (vwe) valid_mem[ent] <= vdata;
    if (state_r == ST_ADD && step && !valid_q_r) begin
      owner_mem[ent] <= cmd_r.id;
      expiry_mem[ent] <= time_r + 32'(cmd_r.delay);
    end
  end

  // Control state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      time_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      pend_r <= 1'b0;
      pend_id_r <= '0;
      ov_r <= 1'b0;
      cmd_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) idx_r <= idx_r + 1'b1;
      if (cmd_take) begin
        cmd_r <= cmd;
        idx_r <= idx_first;
        found_r <= 1'b0;
        pend_r <= 1'b0;
      end
      if (step && emit) begin
        ov_r <= 1'b1;
        ok_r <= ek;
        oid_r <= eid;
        ol_r <= el;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
      if (step) begin
        if (state_r == ST_TICK && due) begin
          pend_r <= 1'b1;
          pend_id_r <= owner_q_r;
        end
        if (state_r == ST_REM && hit) found_r <= 1'b1;
        if (state_r != ST_DONE && !is_end) idx_r <= idx_r + 1'b1;
        // The time moves on when a tick ends its walk, together with its last beat, if any.
        if (state_r == ST_DONE && cmd_r.action == ACT_TICK) time_r <= time_r + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/hashed_timer_wheel.sv
// Top level of the hashed timer wheel.
//
//   channel | direction | fields
//   in_     | input     | action, timer_id, delay_ticks
//   out_    | output    | kind, result_id, last
//
// A command is taken in the idle state; each entry visited takes a read step and
// a work step, and a done step ends the command: a tick walks one slot, an add
// walks one slot up to the first free entry and a remove walks all N_ENTRIES
// (512) entries. The entry walk in the engine sets the rate; a two-deep queue
// lets the input side run ahead. After reset a clearing pass over all N_ENTRIES
// (512) entries empties the valid store before the first command is taken.
// A stalled output holds the engine on the step that produced the next beat.
`timescale 1ns / 1ps
`default_nettype none
module hashed_timer_wheel import htw_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  output logic in_stall,
  input wire logic [1:0] in_action,
  input wire logic [15:0] in_timer_id,
  input wire logic [15:0] in_delay_ticks,
  output logic out_valid,
  input wire logic out_stall,
  output logic [2:0] out_kind,
  output logic [15:0] out_result_id,
  output logic out_last
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  htw_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_timer_id,
    .in_delay_ticks, .cmd_valid, .cmd_take, .cmd
  );

  htw_engine u_engine (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd, .out_valid, .out_stall,
    .out_kind, .out_result_id, .out_last
  );
endmodule
`default_nettype wire
